// ===== rtl/core/dllm_pkg.sv =====
// ----------------------------------------------------------------------------
// dllm_pkg
// Shared types and constants of the doubly linked list manager: pool size,
// link and count widths, opcodes, controller states and link RAM port struct.
// ----------------------------------------------------------------------------
package dllm_pkg;

  localparam int unsigned NODES   = 256;
  localparam int unsigned DEPTH   = NODES + 1;
  localparam int unsigned LINK_W  = $clog2(DEPTH);
  localparam int unsigned NODE_W  = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned OP_W    = 4;

  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam link_t HEAD = link_t'(NODES);

  typedef enum logic [OP_W-1:0] {
    OP_INIT        = 4'd0,
    OP_ADDFIRST    = 4'd1,
    OP_ADDLAST     = 4'd2,
    OP_INSERT      = 4'd3,
    OP_UNLINK      = 4'd4,
    OP_REMOVEFIRST = 4'd5,
    OP_REMOVEALL   = 4'd6,
    OP_FIRST       = 4'd7,
    OP_LAST        = 4'd8,
    OP_PREV        = 4'd9,
    OP_NEXT        = 4'd10
  } op_e;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RD1   = 9'b000000100,
    ST_RD2   = 9'b000001000,
    ST_WR1   = 9'b000010000,
    ST_WR2   = 9'b000100000,
    ST_WALK  = 9'b001000000,
    ST_HEAD  = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic  we;
    link_t waddr;
    link_t wdata;
    logic  re;
    link_t raddr;
  } ram_req_t;

endpackage

// ===== rtl/core/dllm_req_if.sv =====
// ----------------------------------------------------------------------------
// dllm_req_if
// Request channel: opcode, node and position with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dllm_req_if;
  import dllm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [NODE_W-1:0] node_index;
  logic [POS_W-1:0]  position_index;

  modport source (output valid, output opcode, output node_index, output position_index,
                  input ready);
  modport sink   (input valid, input opcode, input node_index, input position_index,
                  output ready);
endinterface

// ===== rtl/core/dllm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dllm_rsp_if
// Result channel: returned node, null flag and list length with valid/ready.
// ----------------------------------------------------------------------------
interface dllm_rsp_if;
  import dllm_pkg::*;

  logic               valid;
  logic               ready;
  logic [LINK_W-1:0]  result_node;
  logic               result_null;
  logic [COUNT_W-1:0] list_length;

  modport source (output valid, output result_node, output result_null, output list_length,
                  input ready);
  modport sink   (input valid, input result_node, input result_null, input list_length,
                  output ready);
endinterface

// ===== rtl/core/doubly_linked_list_manager_core.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_manager_core
// Circular doubly linked list over a pool of 256 nodes with a head sentinel
// at index 256, kept in two link RAMs (next and prev).
//
// After reset a clearing pass self-links every entry; requests are held off
// until it ends. One request is worked on at a time: it is read in two
// dependent RAM reads, then up to two writes per table follow, through the
// states RD1, RD2, WR1, WR2 and FIN back to IDLE. Remove-all walks the list
// one member a cycle, then self-links the head. A new request is accepted
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager_core (
  input logic        clk_i,
  input logic        rst_ni,
  dllm_req_if.sink   req_i,
  dllm_rsp_if.source rsp_o
);
  import dllm_pkg::*;

  state_e          state_q, state_d;
  logic [OP_W-1:0] op_q;
  link_t           n_q;
  logic [POS_W-1:0] p_q;
  link_t           a1_q, a1_d;
  link_t           b1_q, b1_d;
  link_t           t_q, t_d;
  count_t          c_q, c_d;
  link_t           clr_q, clr_d;
  count_t          count_q, count_d;

  logic            rsp_valid_q;
  link_t           rsp_node_q;
  logic            rsp_null_q;
  count_t          rsp_len_q;

  ram_req_t        next_req, prev_req;
  link_t           rd_next, rd_prev;

  logic            p_ok;
  logic            nonempty;
  logic            accept;
  logic            load_rsp;
  logic            has;
  link_t           res;

  dllm_link_ram u_next_ram (
    .clk_i   (clk_i),
    .ram_i   (next_req),
    .rdata_o (rd_next)
  );

  dllm_link_ram u_prev_ram (
    .clk_i   (clk_i),
    .ram_i   (prev_req),
    .rdata_o (rd_prev)
  );

  assign p_ok     = (p_q <= POS_W'(NODES));
  assign nonempty = (count_q != '0);
  assign accept   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // result of the finished request
  always_comb begin
    has = 1'b0;
    res = '0;
    case (op_q)
      OP_REMOVEFIRST, OP_FIRST: begin
        has = nonempty;
        res = a1_q;
      end
      OP_LAST: begin
        has = nonempty;
        res = b1_q;
      end
      OP_PREV: begin
        has = (b1_q != n_q);
        res = b1_q;
      end
      OP_NEXT: begin
        has = (a1_q != n_q);
        res = a1_q;
      end
      default: begin
        has = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    case (op_q)
      OP_ADDFIRST, OP_ADDLAST: count_d = count_q + COUNT_W'(1);
      OP_INSERT:               count_d = p_ok ? count_q + COUNT_W'(1) : count_q;
      OP_UNLINK:               count_d = count_q - COUNT_W'(1);
      OP_REMOVEFIRST:          count_d = nonempty ? count_q - COUNT_W'(1) : count_q;
      OP_REMOVEALL:            count_d = '0;
      default:                 count_d = count_q;
    endcase
  end

  assign load_rsp = (state_q == ST_FIN) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d  = state_q;
    a1_d     = a1_q;
    b1_d     = b1_q;
    t_d      = t_q;
    c_d      = c_q;
    clr_d    = clr_q;
    next_req = '0;
    prev_req = '0;
    case (state_q)
      ST_CLEAR: begin
        next_req.we    = 1'b1;
        next_req.waddr = clr_q;
        next_req.wdata = clr_q;
        prev_req.we    = 1'b1;
        prev_req.waddr = clr_q;
        prev_req.wdata = clr_q;
        clr_d          = clr_q + LINK_W'(1);
        if (clr_q == HEAD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1: begin
        next_req.re = 1'b1;
        prev_req.re = 1'b1;
        case (op_q)
          OP_INSERT:          next_req.raddr = p_ok ? link_t'(p_q) : HEAD;
          OP_UNLINK, OP_NEXT: next_req.raddr = n_q;
          default:            next_req.raddr = HEAD;
        endcase
        prev_req.raddr = (op_q inside {OP_UNLINK, OP_PREV}) ? n_q : HEAD;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        a1_d           = rd_next;
        b1_d           = rd_prev;
        next_req.re    = 1'b1;
        next_req.raddr = (op_q == OP_ADDLAST) ? rd_prev : rd_next;
        prev_req.re    = 1'b1;
        prev_req.raddr = rd_next;
        if (op_q == OP_REMOVEALL) begin
          t_d     = rd_next;
          c_d     = count_q;
          state_d = nonempty ? ST_WALK : ST_HEAD;
        end else begin
          state_d = ST_WR1;
        end
      end
      ST_WR1: begin
        case (op_q)
          OP_INIT: begin
            next_req = '{we: 1'b1, waddr: n_q, wdata: n_q, re: 1'b0, raddr: '0};
            prev_req = '{we: 1'b1, waddr: n_q, wdata: n_q, re: 1'b0, raddr: '0};
          end
          OP_ADDFIRST: begin
            prev_req = '{we: 1'b1, waddr: n_q, wdata: rd_prev, re: 1'b0, raddr: '0};
            next_req = '{we: 1'b1, waddr: n_q, wdata: a1_q, re: 1'b0, raddr: '0};
          end
          OP_ADDLAST: begin
            prev_req = '{we: 1'b1, waddr: n_q, wdata: b1_q, re: 1'b0, raddr: '0};
            next_req = '{we: 1'b1, waddr: n_q, wdata: rd_next, re: 1'b0, raddr: '0};
          end
          OP_INSERT: begin
            next_req = '{we: p_ok, waddr: n_q, wdata: a1_q, re: 1'b0, raddr: '0};
            prev_req = '{we: p_ok, waddr: n_q, wdata: link_t'(p_q), re: 1'b0, raddr: '0};
          end
          OP_UNLINK: begin
            next_req = '{we: 1'b1, waddr: b1_q, wdata: a1_q, re: 1'b0, raddr: '0};
            prev_req = '{we: 1'b1, waddr: a1_q, wdata: b1_q, re: 1'b0, raddr: '0};
          end
          OP_REMOVEFIRST: begin
            prev_req = '{we: nonempty, waddr: rd_next, wdata: HEAD, re: 1'b0, raddr: '0};
            next_req = '{we: nonempty, waddr: HEAD, wdata: rd_next, re: 1'b0, raddr: '0};
          end
          default: begin
            next_req = '0;
            prev_req = '0;
          end
        endcase
        state_d = ST_WR2;
      end
      ST_WR2: begin
        case (op_q)
          OP_ADDFIRST: begin
            prev_req = '{we: 1'b1, waddr: a1_q, wdata: n_q, re: 1'b0, raddr: '0};
            next_req = '{we: 1'b1, waddr: HEAD, wdata: n_q, re: 1'b0, raddr: '0};
          end
          OP_ADDLAST: begin
            prev_req = '{we: 1'b1, waddr: HEAD, wdata: n_q, re: 1'b0, raddr: '0};
            next_req = '{we: 1'b1, waddr: b1_q, wdata: n_q, re: 1'b0, raddr: '0};
          end
          OP_INSERT: begin
            next_req = '{we: p_ok, waddr: link_t'(p_q), wdata: n_q, re: 1'b0, raddr: '0};
            prev_req = '{we: p_ok, waddr: a1_q, wdata: n_q, re: 1'b0, raddr: '0};
          end
          default: begin
            next_req = '0;
            prev_req = '0;
          end
        endcase
        state_d = ST_FIN;
      end
      ST_WALK: begin
        // self-link the current member while fetching the next one
        next_req = '{we: 1'b1, waddr: t_q, wdata: t_q, re: 1'b1, raddr: rd_next};
        prev_req = '{we: 1'b1, waddr: t_q, wdata: t_q, re: 1'b0, raddr: '0};
        t_d      = rd_next;
        c_d      = c_q - COUNT_W'(1);
        if (c_q == COUNT_W'(1)) begin
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        next_req = '{we: 1'b1, waddr: HEAD, wdata: HEAD, re: 1'b0, raddr: '0};
        prev_req = '{we: 1'b1, waddr: HEAD, wdata: HEAD, re: 1'b0, raddr: '0};
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (load_rsp) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      c_q         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      c_q     <= c_d;
      if (load_rsp) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.opcode;
      n_q  <= link_t'(req_i.node_index);
      p_q  <= req_i.position_index;
    end
    a1_q <= a1_d;
    b1_q <= b1_d;
    t_q  <= t_d;
    if (load_rsp) begin
      rsp_node_q <= has ? res : '0;
      rsp_null_q <= !has;
      rsp_len_q  <= count_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.result_node = rsp_node_q;
  assign rsp_o.result_null = rsp_null_q;
  assign rsp_o.list_length = rsp_len_q;

  // no link writes while waiting for a request
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!next_req.we && !prev_req.we))
    else $error("link write while idle");

  // a null result carries node zero
  a_null_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (!rsp_null_q || (rsp_node_q == '0)))
    else $error("null result with a node");

  // the walk never runs with an exhausted counter
  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (c_q != '0))
    else $error("walk with zero count");

  // a result is only loaded into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_rsp && rsp_valid_q) |-> rsp_o.ready)
    else $error("result overwritten");

endmodule

// ===== rtl/core/dllm_link_ram.sv =====
// ----------------------------------------------------------------------------
// dllm_link_ram
// One link table: one write port and one registered read port, old data on
// a read of the entry being written.
// ----------------------------------------------------------------------------
module dllm_link_ram (
  input  logic              clk_i,
  input  dllm_pkg::ram_req_t ram_i,
  output dllm_pkg::link_t   rdata_o
);
  import dllm_pkg::*;

  link_t mem [DEPTH];
  link_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ram_i.we) begin
      mem[ram_i.waddr] <= ram_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_i.re) begin
      rdata_q <= mem[ram_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
